// ----- rtl/core/brrt_pkg.sv -----
// ----------------------------------------------------------------------------
// brrt_pkg
// Shared constants for the bidirectional tree extension core.
// ----------------------------------------------------------------------------
package brrt_pkg;

	localparam int TREE_CAPACITY = 4096;
	localparam int FRACTION_BITS = 14;
	localparam int IDX_W         = $clog2(TREE_CAPACITY);
	localparam int CNT_W         = IDX_W + 1;
	localparam int ADDR_W        = IDX_W + 1;
	localparam int COORD_W       = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GY     = 3'd5;

	// outcome codes
	localparam logic [1:0] OUT_ADDED     = 2'd0;
	localparam logic [1:0] OUT_COLLISION = 2'd1;
	localparam logic [1:0] OUT_FULL      = 2'd2;
	localparam logic [1:0] OUT_EQUAL     = 2'd3;

	// reset values derived from the fraction width
	localparam longint STEP_RST_L = (((64'd3 << FRACTION_BITS) + 64'd50) / 64'd100);
	localparam logic [14:0] STEP_RST   = STEP_RST_L[14:0];
	localparam longint RAD_RST_L  = 64'd1 << (FRACTION_BITS - 1);
	localparam logic [14:0] RADIUS_RST = RAD_RST_L[14:0];
	localparam longint START_RST_L = 64'd0 - (64'd1 << (FRACTION_BITS - 1));
	localparam logic [15:0] START_RST  = START_RST_L[15:0];
	localparam longint GOAL_RST_L = 64'd1 << FRACTION_BITS;
	localparam logic [15:0] GOAL_RST   = GOAL_RST_L[15:0];

endpackage

// ----- rtl/core/brrt_if.sv -----
// ----------------------------------------------------------------------------
// brrt sample and result channels
// Valid/ready channels carrying sample points and extension results.
// ----------------------------------------------------------------------------
interface brrt_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_x;
	logic signed [15:0] sample_y;

	modport source (output valid, output sample_x, output sample_y, input ready);
	modport sink (input valid, input sample_x, input sample_y, output ready);
endinterface

interface brrt_result_if;
	logic               valid;
	logic               ready;
	logic               tree_side;
	logic [1:0]         outcome;
	logic signed [15:0] new_x;
	logic signed [15:0] new_y;
	logic [11:0]        parent_index;
	logic [11:0]        node_index;
	logic               last;

	modport source (output valid, output tree_side, output outcome, output new_x,
		output new_y, output parent_index, output node_index, output last, input ready);
	modport sink (input valid, input tree_side, input outcome, input new_x,
		input new_y, input parent_index, input node_index, input last, output ready);
endinterface

// ----- rtl/core/brrt_node_mem.sv -----
// ----------------------------------------------------------------------------
// brrt_node_mem
// Node store for both trees, one write and one registered read port.
// ----------------------------------------------------------------------------
module brrt_node_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [brrt_pkg::ADDR_W-1:0]   waddr,
	input  logic [2*brrt_pkg::COORD_W-1:0] wdata,
	input  logic                          re,
	input  logic [brrt_pkg::ADDR_W-1:0]   raddr,
	output logic [2*brrt_pkg::COORD_W-1:0] rdata
);

	logic [2*brrt_pkg::COORD_W-1:0] mem [2*brrt_pkg::TREE_CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/brrt_isqrt.sv -----
// ----------------------------------------------------------------------------
// brrt_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module brrt_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [34:0] value,
	output logic        done,
	output logic [17:0] root
);

	logic [35:0] v_q;
	logic [35:0] res_q;
	logic [35:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 36'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= {1'b0, value};
			res_q <= 36'd0;
			bit_q <= 36'd1 << 34;
		end else if (busy_q && bit_q != 36'd0) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[17:0];

endmodule

// ----- rtl/core/brrt_div.sv -----
// ----------------------------------------------------------------------------
// brrt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brrt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,
	input  logic [18:0] den,
	output logic        done,
	output logic [32:0] quo
);

	logic [32:0] n_q;
	logic [19:0] rem_q;
	logic [18:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [19:0] rem_sh;
	logic        qbit;

	assign rem_sh = {rem_q[18:0], n_q[32]};
	assign qbit   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= 20'd0;
			den_q <= den;
		end else if (busy_q && cnt_q != 6'd0) begin
			rem_q <= qbit ? rem_sh - {1'b0, den_q} : rem_sh;
			n_q   <= {n_q[31:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

// ----- rtl/core/bidirectional_rrt_extend_core.sv -----
// ----------------------------------------------------------------------------
// bidirectional_rrt_extend_core
// Extends a forward and a backward tree toward each sample point.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | word
//  smp     | in  | valid/ready | sample_x, sample_y
//  res     | out | valid/ready | tree_side, outcome, new_x, new_y, parent_index,
//          |     |             | node_index, last (two words per sample)
//  cfg     | in  | we only     | cfg_index, cfg_data
//
// per tree, the nearest node scan reads one node per cycle from the node memory,
// then a square root and two divides run.
// reset leaves each tree holding only its root, which lives in registers.
// a stalled result holds the core; a new sample is taken only when idle.
module bidirectional_rrt_extend_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [brrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brrt_pkg::CFG_DATA_W-1:0]  cfg_data,
	brrt_sample_if.sink                      smp,
	brrt_result_if.source                    res
);

	localparam int IW = brrt_pkg::IDX_W;
	localparam int CW = brrt_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_SQRT_GO, ST_SQRT_W, ST_MUL,
		ST_DIVX_GO, ST_DIVX_W, ST_DIVY_GO, ST_DIVY_W, ST_NEWPT, ST_COLL,
		ST_DECIDE, ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [14:0]        step_q;
	logic [14:0]        radius_q;
	logic signed [15:0] start_x_q, start_y_q, goal_x_q, goal_y_q;

	logic [CW-1:0]      fwd_cnt_q, bwd_cnt_q, n_cnt;
	logic signed [15:0] sx_q, sy_q;
	logic               side_q;
	logic [CW-1:0]      idx_q;

	// scan pipeline
	logic               v_s1, v_s2, v_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	logic signed [16:0] ex_s2, ey_s2;
	logic signed [15:0] px_s2, py_s2, px_s3, py_s3;
	logic [33:0]        sqx_s3, sqy_s3;
	logic [34:0]        best_d_q, cand_d;
	logic [IW-1:0]      best_i_q;
	logic signed [15:0] best_x_q, best_y_q;

	// extension math
	logic signed [16:0] dx_q, dy_q;
	logic signed [32:0] prodx_q, prody_q;
	logic [32:0]        absx, absy;
	logic [17:0]        len_q;
	logic [32:0]        qx_q;
	logic signed [15:0] newx_q, newy_q;
	logic [31:0]        sqnx_q, sqny_q;
	logic [29:0]        r2_q;

	// result word
	logic               o_side_q;
	logic [1:0]         o_outcome_q;
	logic signed [15:0] o_x_q, o_y_q;
	logic [11:0]        o_parent_q, o_node_q;

	// memory and units
	logic                             mem_we;
	logic [brrt_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
	logic [2*brrt_pkg::COORD_W-1:0]   mem_wdata, mem_rdata;
	logic                             sqrt_done, div_done, div_start;
	logic [17:0]                      sqrt_root;
	logic [32:0]                      div_num, div_quo;
	logic signed [15:0]               root_x, root_y, rd_x, rd_y;
	logic signed [15:0]               nx_c, ny_c;
	logic                             collide;

	function automatic logic signed [15:0] add_sat(logic signed [15:0] base,
		logic [32:0] mag, logic neg);
		logic signed [34:0] s;
		s = $signed({{19{base[15]}}, base}) +
			(neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
		if (s > 35'sd32767) begin
			return 16'sh7fff;
		end else if (s < -35'sd32768) begin
			return 16'sh8000;
		end
		return s[15:0];
	endfunction

	assign n_cnt  = side_q ? bwd_cnt_q : fwd_cnt_q;
	assign root_x = side_q ? goal_x_q : start_x_q;
	assign root_y = side_q ? goal_y_q : start_y_q;
	assign rd_x   = (idx_s1 == '0) ? root_x : $signed(mem_rdata[15:0]);
	assign rd_y   = (idx_s1 == '0) ? root_y : $signed(mem_rdata[31:16]);
	assign cand_d = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	assign absx    = prodx_q[32] ? 33'(-prodx_q) : 33'(prodx_q);
	assign absy    = prody_q[32] ? 33'(-prody_q) : 33'(prody_q);
	// round half away from zero: (2a + len) / (2 len)
	assign div_num = (state_q == ST_DIVY_GO) ? {absy[31:0], 1'b0} + 33'(len_q)
		: {absx[31:0], 1'b0} + 33'(len_q);
	assign div_start = (state_q == ST_DIVX_GO) || (state_q == ST_DIVY_GO);

	assign nx_c = add_sat(best_x_q, qx_q, prodx_q[32]);
	assign ny_c = add_sat(best_y_q, div_quo, prody_q[32]);
	assign collide = ({1'b0, sqnx_q} + {1'b0, sqny_q}) < {3'b000, r2_q};

	assign mem_raddr = {side_q, idx_q[IW-1:0]};
	assign mem_we    = (state_q == ST_DECIDE) && !collide && !n_cnt[CW-1];
	assign mem_waddr = {side_q, n_cnt[IW-1:0]};
	assign mem_wdata = {newy_q, newx_q};

	brrt_node_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (state_q == ST_SCAN),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	brrt_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SQRT_GO),
		.value  (best_d_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	brrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({len_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= brrt_pkg::STEP_RST;
			radius_q  <= brrt_pkg::RADIUS_RST;
			start_x_q <= brrt_pkg::START_RST;
			start_y_q <= brrt_pkg::START_RST;
			goal_x_q  <= brrt_pkg::GOAL_RST;
			goal_y_q  <= brrt_pkg::GOAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				brrt_pkg::REG_STEP:   step_q    <= cfg_data[14:0];
				brrt_pkg::REG_RADIUS: radius_q  <= cfg_data[14:0];
				brrt_pkg::REG_SX:     start_x_q <= cfg_data;
				brrt_pkg::REG_SY:     start_y_q <= cfg_data;
				brrt_pkg::REG_GX:     goal_x_q  <= cfg_data;
				brrt_pkg::REG_GY:     goal_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// scan pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
		ex_s2  <= 17'(sx_q) - 17'(rd_x);
		ey_s2  <= 17'(sy_q) - 17'(rd_y);
		px_s2  <= rd_x;
		py_s2  <= rd_y;
		idx_s2 <= idx_s1;
		sqx_s3 <= 34'(ex_s2 * ex_s2);
		sqy_s3 <= 34'(ey_s2 * ey_s2);
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		idx_s3 <= idx_s2;
	end

	// control and datapath sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fwd_cnt_q <= CW'(1);
			bwd_cnt_q <= CW'(1);
			side_q    <= 1'b0;
			idx_q     <= '0;
			best_d_q  <= '1;
		end else begin
			if (v_s3 && cand_d < best_d_q) begin
				best_d_q <= cand_d;
				best_i_q <= idx_s3;
				best_x_q <= px_s3;
				best_y_q <= py_s3;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp.valid) begin
						sx_q     <= smp.sample_x;
						sy_q     <= smp.sample_y;
						side_q   <= 1'b0;
						idx_q    <= '0;
						best_d_q <= '1;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == n_cnt - CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						dx_q <= 17'(sx_q) - 17'(best_x_q);
						dy_q <= 17'(sy_q) - 17'(best_y_q);
						o_side_q   <= side_q;
						o_parent_q <= 12'(best_i_q);
						o_node_q   <= 12'd0;
						if (best_d_q == 35'd0) begin
							o_outcome_q <= brrt_pkg::OUT_EQUAL;
							o_x_q       <= best_x_q;
							o_y_q       <= best_y_q;
							state_q     <= ST_EMIT;
						end else begin
							state_q <= ST_SQRT_GO;
						end
					end
				end
				ST_SQRT_GO: state_q <= ST_SQRT_W;
				ST_SQRT_W: begin
					if (sqrt_done) begin
						len_q   <= sqrt_root;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prodx_q <= $signed({1'b0, step_q}) * dx_q;
					prody_q <= $signed({1'b0, step_q}) * dy_q;
					state_q <= ST_DIVX_GO;
				end
				ST_DIVX_GO: state_q <= ST_DIVX_W;
				ST_DIVX_W: begin
					if (div_done) begin
						qx_q    <= div_quo;
						state_q <= ST_DIVY_GO;
					end
				end
				ST_DIVY_GO: state_q <= ST_DIVY_W;
				ST_DIVY_W: begin
					if (div_done) begin
						state_q <= ST_NEWPT;
					end
				end
				ST_NEWPT: begin
					// divider still holds the y quotient here
					newx_q  <= nx_c;
					newy_q  <= ny_c;
					state_q <= ST_COLL;
				end
				ST_COLL: begin
					sqnx_q  <= 32'(newx_q * newx_q);
					sqny_q  <= 32'(newy_q * newy_q);
					r2_q    <= 30'(radius_q * radius_q);
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					o_x_q <= newx_q;
					o_y_q <= newy_q;
					if (collide) begin
						o_outcome_q <= brrt_pkg::OUT_COLLISION;
					end else if (n_cnt[CW-1]) begin
						o_outcome_q <= brrt_pkg::OUT_FULL;
					end else begin
						o_outcome_q <= brrt_pkg::OUT_ADDED;
						o_node_q    <= 12'(n_cnt[IW-1:0]);
						if (side_q) begin
							bwd_cnt_q <= bwd_cnt_q + CW'(1);
						end else begin
							fwd_cnt_q <= fwd_cnt_q + CW'(1);
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res.ready) begin
						if (!side_q) begin
							side_q   <= 1'b1;
							idx_q    <= '0;
							best_d_q <= '1;
							state_q  <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign smp.ready        = (state_q == ST_IDLE);
	assign res.valid        = (state_q == ST_EMIT);
	assign res.tree_side    = o_side_q;
	assign res.outcome      = o_outcome_q;
	assign res.new_x        = o_x_q;
	assign res.new_y        = o_y_q;
	assign res.parent_index = o_parent_q;
	assign res.node_index   = o_node_q;
	assign res.last         = o_side_q;

endmodule

// ----- rtl/core/brrt_checker.sv -----
// ----------------------------------------------------------------------------
// brrt_checker
// Port level checks on the tree extension core.
// ----------------------------------------------------------------------------
module brrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_side,
	input logic [1:0]  out_outcome,
	input logic [11:0] out_node,
	input logic        out_last
);

	// a taken sample keeps the core busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted back to back");

	// no new sample while a result word is pending
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready while result pending");

	// backward word closes the pair
	a_last_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == out_side)
		else $error("last does not match tree side");

	// only an added node carries a nonzero index
	a_node_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_outcome == brrt_pkg::OUT_ADDED) == (out_node != 12'd0)))
		else $error("node index inconsistent with outcome");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_side))
		else $error("result word dropped while stalled");

endmodule

bind bidirectional_rrt_extend_core brrt_checker u_brrt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (smp.valid),
	.in_ready    (smp.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_side    (res.tree_side),
	.out_outcome (res.outcome),
	.out_node    (res.node_index),
	.out_last    (res.last)
);

// ----- verif/bidirectional_rrt_extend_core_tb.sv -----
// ----------------------------------------------------------------------------
// bidirectional_rrt_extend_core_tb
// Self-checking bench for the two-tree extension core. A short stimulus
// table runs first, then random samples under several register settings.
// Every sample is predicted by a model of both trees. Results are compared
// whole, in order; both channels idle and stall at random but in one phase.
// ----------------------------------------------------------------------------
module bidirectional_rrt_extend_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               tree_side;
		logic [1:0]         outcome;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic [11:0]        parent_index;
		logic [11:0]        node_index;
		logic               last;
	} ext_word_t;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		bit                 typed;
		logic               side;
		logic [1:0]         outcome;
	} sample_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [brrt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [brrt_pkg::CFG_DATA_W-1:0] cfg_data;

	brrt_sample_if smp();
	brrt_result_if res();

	bidirectional_rrt_extend_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.smp       (smp),
		.res       (res)
	);

	// tree model
	longint    node_x [2][brrt_pkg::TREE_CAPACITY];
	longint    node_y [2][brrt_pkg::TREE_CAPACITY];
	int        node_cnt [2];
	longint    step_len;
	longint    obst_rad;
	ext_word_t pending_words[$];
	ext_word_t last_pred [2];
	int        n_fail;
	bit        quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// nearest to the quotient, halves away from zero
	function automatic longint round_div(longint num, longint den);
		longint a, q;
		a = (num < 0) ? -num : num;
		q = (2 * a + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic ext_word_t extend_tree(int side, longint sx, longint sy);
		ext_word_t w;
		int n, best;
		longint best_d, d, dx, dy, nx, ny, px, py, len;
		n = node_cnt[side];
		best = 0;
		best_d = -1;
		for (int i = 0; i < n; i++) begin
			dx = sx - node_x[side][i];
			dy = sy - node_y[side][i];
			d = dx * dx + dy * dy;
			if (best_d < 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		px = node_x[side][best];
		py = node_y[side][best];
		dx = sx - px;
		dy = sy - py;
		w.tree_side = side[0];
		w.last = side[0];
		w.parent_index = best[11:0];
		w.node_index = '0;
		if (dx == 0 && dy == 0) begin
			w.outcome = brrt_pkg::OUT_EQUAL;
			nx = px;
			ny = py;
		end else begin
			len = longint'(int_sqrt(dx * dx + dy * dy));
			nx = clip16(px + round_div(step_len * dx, len));
			ny = clip16(py + round_div(step_len * dy, len));
			if (nx * nx + ny * ny < obst_rad * obst_rad) begin
				w.outcome = brrt_pkg::OUT_COLLISION;
			end else if (n >= brrt_pkg::TREE_CAPACITY) begin
				w.outcome = brrt_pkg::OUT_FULL;
			end else begin
				node_x[side][n] = nx;
				node_y[side][n] = ny;
				node_cnt[side] = n + 1;
				w.node_index = n[11:0];
				w.outcome = brrt_pkg::OUT_ADDED;
			end
		end
		w.new_x = nx[15:0];
		w.new_y = ny[15:0];
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [brrt_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			brrt_pkg::REG_STEP:   step_len = longint'(val[14:0]);
			brrt_pkg::REG_RADIUS: obst_rad = longint'(val[14:0]);
			brrt_pkg::REG_SX:     node_x[0][0] = longint'($signed(val));
			brrt_pkg::REG_SY:     node_y[0][0] = longint'($signed(val));
			brrt_pkg::REG_GX:     node_x[1][0] = longint'($signed(val));
			brrt_pkg::REG_GY:     node_y[1][0] = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic send_sample(logic signed [15:0] sx, logic signed [15:0] sy);
		if (!quiet && $urandom_range(99) < 13) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.sample_x <= sx;
		smp.sample_y <= sy;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		for (int s = 0; s < 2; s++) begin
			last_pred[s] = extend_tree(s, longint'(sx), longint'(sy));
			pending_words.push_back(last_pred[s]);
		end
	endtask

	task automatic pick_sample(output logic signed [15:0] sx, output logic signed [15:0] sy);
		int r, side, k;
		r = $urandom_range(99);
		if (r < 10) begin
			sx = 16'($urandom);
			sy = 16'($urandom);
		end else if (r < 20) begin
			// land exactly on a stored node
			side = $urandom_range(1);
			k = $urandom_range(node_cnt[side] - 1);
			sx = node_x[side][k][15:0];
			sy = node_y[side][k][15:0];
		end else begin
			sx = 16'($urandom_range(48000) - 24000);
			sy = 16'($urandom_range(48000) - 24000);
		end
	endtask

	task automatic run_random(int count);
		logic signed [15:0] sx, sy;
		for (int i = 0; i < count; i++) begin
			pick_sample(sx, sy);
			send_sample(sx, sy);
		end
		smp.valid <= 1'b0;
	endtask

	// result side
	initial begin
		ext_word_t got, want;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				got = '{res.tree_side, res.outcome, res.new_x, res.new_y,
					res.parent_index, res.node_index, res.last};
				if (pending_words.size() == 0) begin
					n_fail++;
					$display("%0t unexpected word %p", $realtime, got);
				end else begin
					want = pending_words.pop_front();
					if (got !== want) begin
						n_fail++;
						$display("%0t word mismatch expected %p actual %p", $realtime, want, got);
					end
				end
			end
			res.ready <= quiet || ($urandom_range(99) >= 13);
		end
	end

	sample_row_t rows[$] = '{
		'{-16'sd8192, -16'sd8192, 1'b1, 1'b0, brrt_pkg::OUT_EQUAL},
		'{16'sd16384, 16'sd16384, 1'b1, 1'b1, brrt_pkg::OUT_EQUAL},
		'{16'sd32767, 16'sd32767, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{-16'sd32768, -16'sd32768, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{-16'sd32768, 16'sd32767, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{16'sd32767, -16'sd32768, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{16'sd0, 16'sd0, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{16'sd0, 16'sd0, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{-16'sd8192, 16'sd0, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{16'sd1, -16'sd1, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{16'sd21845, -16'sd21846, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{-16'sd21846, 16'sd21845, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{16'sd4000, 16'sd4000, 1'b0, 1'b0, brrt_pkg::OUT_ADDED},
		'{-16'sd8192, -16'sd8192, 1'b1, 1'b0, brrt_pkg::OUT_EQUAL},
		'{16'sd16384, 16'sd16384, 1'b1, 1'b1, brrt_pkg::OUT_EQUAL},
		'{16'sd16000, 16'sd16384, 1'b0, 1'b0, brrt_pkg::OUT_ADDED}
	};

	initial begin
		n_fail = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		smp.valid = 1'b0;
		smp.sample_x = '0;
		smp.sample_y = '0;
		step_len = longint'(brrt_pkg::STEP_RST);
		obst_rad = longint'(brrt_pkg::RADIUS_RST);
		node_x[0][0] = longint'($signed(brrt_pkg::START_RST));
		node_y[0][0] = longint'($signed(brrt_pkg::START_RST));
		node_x[1][0] = longint'($signed(brrt_pkg::GOAL_RST));
		node_y[1][0] = longint'($signed(brrt_pkg::GOAL_RST));
		node_cnt[0] = 1;
		node_cnt[1] = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) begin
			send_sample(rows[i].sx, rows[i].sy);
			if (rows[i].typed && last_pred[rows[i].side].outcome !== rows[i].outcome) begin
				n_fail++;
				$display("%0t table row %0d expected outcome %0d actual %0d", $realtime, i,
					rows[i].outcome, last_pred[rows[i].side].outcome);
			end
		end
		smp.valid <= 1'b0;

		// zero step: new point is the nearest node itself
		wait_drained();
		write_reg(brrt_pkg::REG_STEP, 16'd0);
		write_reg(brrt_pkg::REG_RADIUS, 16'd0);
		write_reg(3'd6, 16'hffff);
		run_random(15);

		wait_drained();
		write_reg(brrt_pkg::REG_STEP, 16'h7fff);
		write_reg(brrt_pkg::REG_RADIUS, 16'h7fff);
		write_reg(brrt_pkg::REG_SX, 16'h8000);
		write_reg(brrt_pkg::REG_SY, 16'h8000);
		write_reg(brrt_pkg::REG_GX, 16'h7fff);
		write_reg(brrt_pkg::REG_GY, 16'h7fff);
		run_random(20);

		wait_drained();
		write_reg(brrt_pkg::REG_STEP, 16'd1);
		write_reg(brrt_pkg::REG_RADIUS, 16'd0);
		write_reg(brrt_pkg::REG_SX, 16'h7fff);
		write_reg(brrt_pkg::REG_SY, 16'h8000);
		write_reg(brrt_pkg::REG_GX, 16'h0000);
		write_reg(brrt_pkg::REG_GY, 16'hffff);
		write_reg(3'd7, 16'h1234);
		run_random(15);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_reg(brrt_pkg::REG_STEP, 16'($urandom_range(1, 4000)));
			write_reg(brrt_pkg::REG_RADIUS, 16'($urandom_range(0, 12000)));
			write_reg(brrt_pkg::REG_SX, 16'($urandom));
			write_reg(brrt_pkg::REG_SY, 16'($urandom));
			write_reg(brrt_pkg::REG_GX, 16'($urandom));
			write_reg(brrt_pkg::REG_GY, 16'($urandom));
			quiet = (ph == 1);
			run_random(12);
			// sender holds off until every word is back
			if (ph == 2) begin
				while (pending_words.size() != 0) @(posedge clk);
			end
			run_random(10);
		end
		quiet = 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (n_fail == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/brrt_pkg.sv
rtl/core/brrt_if.sv
rtl/core/brrt_node_mem.sv
rtl/core/brrt_isqrt.sv
rtl/core/brrt_div.sv
rtl/core/bidirectional_rrt_extend_core.sv
rtl/core/brrt_checker.sv
verif/bidirectional_rrt_extend_core_tb.sv
